// ===== hw/rtl/hfs_pkg.sv =====
`timescale 1ns / 1ps
package hfs_pkg;

	localparam int INV_W       = 24;
	localparam int POS_W       = 32;
	localparam int PROD_W      = 56;
	localparam int FRAC_BITS   = 16;
	localparam int FRAC_LSB    = 16;
	localparam int CELL_LSB    = 32;
	localparam int WEIGHT_W    = 17;
	localparam int OUT_W       = 16;
	localparam int ROUND_HALF  = 32768;

	localparam logic [INV_W-1:0]    INV_RESET  = 24'd65536;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                    operation;
		logic [8:0]              grid_row;
		logic [8:0]              grid_col;
		logic [15:0]             height_value;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_z;
	} in_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] sampled_height;
		logic             outside;
	} out_word_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] frac_x;
		logic [FRAC_BITS-1:0] frac_z;
		logic                 lower;
		logic                 row_odd;
		logic                 col_odd;
		logic                 outside;
	} corner_sel_t;

endpackage

// ===== hw/rtl/heightfield_height_sampler_unit.sv =====
// A query word passes through stages s1 to s5 and is offered on rsp from s5.
// Throughput: one word per cycle unless rsp stalls; writes end at s2 with no result.
// A stall on rsp holds only the full stages, so empty stages still take new words.
// Reset clears every valid bit and sets inv_cell_length to 1.0; the height store
// is not cleared and holds undefined values until written.
`timescale 1ns / 1ps
module heightfield_height_sampler_unit import hfs_pkg::*; #(
	parameter int GRID_DEPTH  = 8,
	parameter int HEIGHT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  in_word_t         req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output out_word_t        rsp,
	input  logic             cfg_we,
	input  logic [INV_W-1:0] cfg_wdata
);

	localparam int HALF       = (1 << (GRID_DEPTH - 1)) + 1;
	localparam int BANK_WORDS = HALF * HALF;
	localparam int ADDR_W     = $clog2(BANK_WORDS);

	logic [INV_W-1:0]             inv_q;
	logic                         v_s1;
	logic                         v_s2;
	logic                         v_s3;
	logic                         v_s4;
	logic                         v_s5;
	pipe_en_t                     en;
	logic                         is_query_s2;
	logic                         wr_hit_s2;
	logic [1:0]                   wr_bank_s2;
	logic [ADDR_W-1:0]            wr_addr_s2;
	logic [HEIGHT_BITS-1:0]       wr_data_s2;
	logic [3:0][ADDR_W-1:0]       rd_addr;
	logic [3:0][HEIGHT_BITS-1:0]  bank_data;
	corner_sel_t                  sel_s3;
	out_word_t                    rsp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_RESET;
		end else if (cfg_we) begin
			inv_q <= cfg_wdata;
		end
	end

	assign en.s5 = !v_s5 || !rsp_stall;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= req_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2 && is_query_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	hfs_front #(
		.GRID_DEPTH  (GRID_DEPTH),
		.HEIGHT_BITS (HEIGHT_BITS),
		.ADDR_W      (ADDR_W)
	) u_front (
		.clk             (clk),
		.en              (en),
		.inv_cell_length (inv_q),
		.req             (req),
		.is_query_s2     (is_query_s2),
		.wr_hit_s2       (wr_hit_s2),
		.wr_bank_s2      (wr_bank_s2),
		.wr_addr_s2      (wr_addr_s2),
		.wr_data_s2      (wr_data_s2),
		.rd_addr         (rd_addr),
		.sel_s3          (sel_s3)
	);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		hfs_bank_mem #(
			.ADDR_W (ADDR_W),
			.DATA_W (HEIGHT_BITS),
			.WORDS  (BANK_WORDS)
		) u_bank (
			.clk     (clk),
			.wr_en   (en.s3 && v_s2 && wr_hit_s2 && (wr_bank_s2 == 2'(b))),
			.wr_addr (wr_addr_s2),
			.wr_data (wr_data_s2),
			.rd_en   (en.s3),
			.rd_addr (rd_addr[b]),
			.rd_data (bank_data[b])
		);
	end

	hfs_interp #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_interp (
		.clk       (clk),
		.en        (en),
		.sel_s3    (sel_s3),
		.bank_data (bank_data),
		.rsp_s5    (rsp_s5)
	);

	assign req_stall = !en.s1;
	assign rsp_valid = v_s5;
	assign rsp       = rsp_s5;

endmodule

// ===== hw/rtl/hfs_bank_mem.sv =====
`timescale 1ns / 1ps
module hfs_bank_mem #(
	parameter int ADDR_W = 15,
	parameter int DATA_W = 16,
	parameter int WORDS  = 16641
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [WORDS];
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== hw/rtl/hfs_front.sv =====
`timescale 1ns / 1ps
module hfs_front import hfs_pkg::*; #(
	parameter int GRID_DEPTH  = 8,
	parameter int HEIGHT_BITS = 16,
	parameter int ADDR_W      = $clog2(((1 << (GRID_DEPTH - 1)) + 1) * ((1 << (GRID_DEPTH - 1)) + 1))
) (
	input  logic                        clk,
	input  pipe_en_t                    en,
	input  logic [INV_W-1:0]            inv_cell_length,
	input  in_word_t                    req,
	output logic                        is_query_s2,
	output logic                        wr_hit_s2,
	output logic [1:0]                  wr_bank_s2,
	output logic [ADDR_W-1:0]           wr_addr_s2,
	output logic [HEIGHT_BITS-1:0]      wr_data_s2,
	output logic [3:0][ADDR_W-1:0]      rd_addr,
	output corner_sel_t                 sel_s3
);

	localparam int GRID_SIDE = (1 << GRID_DEPTH) + 1;
	localparam int HW        = (GRID_DEPTH > 8) ? GRID_DEPTH : 8;
	localparam int SW        = 2 * HW + 1;

	function automatic logic [ADDR_W-1:0] bank_addr(input logic [HW-1:0] rh,
			input logic [HW-1:0] ch);
		logic [SW-1:0] a;
		a = (SW'(rh) << (GRID_DEPTH - 1)) + SW'(rh) + SW'(ch);
		return a[ADDR_W-1:0];
	endfunction

	in_word_t                  word_s1;
	logic signed [PROD_W-1:0]  prod_x_c;
	logic signed [PROD_W-1:0]  prod_z_c;
	logic signed [PROD_W-1:0]  prod_x_s2;
	logic signed [PROD_W-1:0]  prod_z_s2;
	logic                      wr_ok_c;
	logic [GRID_DEPTH-1:0]     cell_r;
	logic [GRID_DEPTH-1:0]     cell_c;
	logic                      out_x;
	logic                      out_z;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			word_s1 <= req;
		end
	end

	assign prod_x_c = PROD_W'(word_s1.pos_x) * PROD_W'($signed({1'b0, inv_cell_length}));
	assign prod_z_c = PROD_W'(word_s1.pos_z) * PROD_W'($signed({1'b0, inv_cell_length}));
	assign wr_ok_c  = (32'(word_s1.grid_row) < 32'(GRID_SIDE))
		&& (32'(word_s1.grid_col) < 32'(GRID_SIDE));

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_x_s2   <= prod_x_c;
			prod_z_s2   <= prod_z_c;
			is_query_s2 <= (word_s1.operation == OP_QUERY);
			wr_hit_s2   <= (word_s1.operation == OP_WRITE) && wr_ok_c;
			wr_bank_s2  <= {word_s1.grid_row[0], word_s1.grid_col[0]};
			wr_addr_s2  <= bank_addr(HW'(word_s1.grid_row[8:1]), HW'(word_s1.grid_col[8:1]));
			wr_data_s2  <= HEIGHT_BITS'(word_s1.height_value);
		end
	end

	assign cell_r = prod_z_s2[CELL_LSB +: GRID_DEPTH];
	assign cell_c = prod_x_s2[CELL_LSB +: GRID_DEPTH];
	assign out_x  = prod_x_s2[PROD_W-1] || (|prod_x_s2[PROD_W-2:CELL_LSB+GRID_DEPTH]);
	assign out_z  = prod_z_s2[PROD_W-1] || (|prod_z_s2[PROD_W-2:CELL_LSB+GRID_DEPTH]);

	// Each bank holds one row parity and one column parity, so the four
	// corners of any cell sit in four different banks.
	always_comb begin
		logic [HW-1:0] rh;
		logic [HW-1:0] ch;
		rh = '0;
		ch = '0;
		for (int b = 0; b < 4; b++) begin
			rh = HW'(cell_r >> 1) + HW'(cell_r[0] && (b < 2));
			ch = HW'(cell_c >> 1) + HW'(cell_c[0] && ((b & 1) == 0));
			rd_addr[b] = bank_addr(rh, ch);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sel_s3.frac_x  <= prod_x_s2[FRAC_LSB +: FRAC_BITS];
			sel_s3.frac_z  <= prod_z_s2[FRAC_LSB +: FRAC_BITS];
			sel_s3.lower   <= prod_x_s2[FRAC_LSB +: FRAC_BITS] < prod_z_s2[FRAC_LSB +: FRAC_BITS];
			sel_s3.row_odd <= cell_r[0];
			sel_s3.col_odd <= cell_c[0];
			sel_s3.outside <= out_x || out_z;
		end
	end

endmodule

// ===== hw/rtl/hfs_interp.sv =====
`timescale 1ns / 1ps
module hfs_interp import hfs_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                         clk,
	input  pipe_en_t                     en,
	input  corner_sel_t                  sel_s3,
	input  logic [3:0][HEIGHT_BITS-1:0]  bank_data,
	output out_word_t                    rsp_s5
);

	localparam int PW    = HEIGHT_BITS + WEIGHT_W;
	localparam int ACC_W = (PW + 1 > FRAC_BITS + OUT_W) ? PW + 1 : FRAC_BITS + OUT_W;

	logic [1:0]             i00;
	logic [1:0]             imid;
	logic [WEIGHT_W-1:0]    fx;
	logic [WEIGHT_W-1:0]    fz;
	logic [WEIGHT_W-1:0]    w0;
	logic [WEIGHT_W-1:0]    wm;
	logic [WEIGHT_W-1:0]    w1;
	logic [2:0][PW-1:0]     prod_s4;
	logic                   outside_s4;
	logic [ACC_W-1:0]       acc;

	assign i00  = {sel_s3.row_odd, sel_s3.col_odd};
	assign imid = sel_s3.lower ? {~sel_s3.row_odd, sel_s3.col_odd}
		: {sel_s3.row_odd, ~sel_s3.col_odd};
	assign fx   = WEIGHT_W'(sel_s3.frac_x);
	assign fz   = WEIGHT_W'(sel_s3.frac_z);
	assign w0   = sel_s3.lower ? WEIGHT_ONE - fz : WEIGHT_ONE - fx;
	assign wm   = sel_s3.lower ? fz - fx : fx - fz;
	assign w1   = sel_s3.lower ? fx : fz;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_s4[0] <= PW'(bank_data[i00]) * PW'(w0);
			prod_s4[1] <= PW'(bank_data[imid]) * PW'(wm);
			prod_s4[2] <= PW'(bank_data[~i00]) * PW'(w1);
			outside_s4 <= sel_s3.outside;
		end
	end

	assign acc = ACC_W'(prod_s4[0]) + ACC_W'(prod_s4[1]) + ACC_W'(prod_s4[2])
		+ ACC_W'(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			rsp_s5.outside        <= outside_s4;
			rsp_s5.sampled_height <= outside_s4 ? '0 : acc[FRAC_BITS +: OUT_W];
		end
	end

endmodule

// ===== hw/rtl/hfs_checker.sv =====
`timescale 1ns / 1ps
module hfs_checker import hfs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input out_word_t rsp
);

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.outside |-> rsp.sampled_height == '0)
		else $error("An outside word carries a non-zero height.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("A stalled result word changed or vanished.");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("Input stalled although the output side is free.");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid && !req_stall)
		else $error("Pipeline not empty on leaving reset.");

endmodule

bind heightfield_height_sampler_unit hfs_checker u_hfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
